/* rtl/lppr_pkg.sv */
// Package for the length-prefixed packet receiver.
// Holds item structs, controller state enum, command/status structs, sizes.
// No dependencies.
package lppr_pkg;

  // Largest packet kept in the payload store.
  localparam int unsigned MaxPacket = 16;
  localparam int unsigned AddrW     = $clog2(MaxPacket);
  localparam int unsigned LenW      = $clog2(MaxPacket + 1);
  // Position runs 0 .. MaxPacket + 1: two header bytes, then data.
  localparam int unsigned PosW      = $clog2(MaxPacket + 2);

  // Input operation codes.
  localparam logic OpByte = 1'b0;
  localparam logic OpAck  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic [3:0] byte_index;
    logic [4:0] packet_length;
    logic       last_of_packet;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_READ,
    ST_SEND
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic step_en;   // apply the input item to the receive state
    logic rd_en;     // read the store at the run counter
    logic cnt_inc;   // advance the run counter
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic run_start; // this data byte completes a packet
    logic run_last;  // run counter is at the final byte
  } dp_status_t;

endpackage

/* rtl/lppr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module lppr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lppr_ctrl.sv */
// Controller for the packet receiver: receive, store read, and send states.
// Depends on lppr_pkg.
module lppr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  lppr_pkg::dp_status_t status_i,
  output lppr_pkg::ctrl_cmd_t  cmd_o
);
  import lppr_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RECV;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RECV: begin
        if (in_valid_i && status_i.run_start) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (!out_stall_i) begin
          state_d = status_i.run_last ? ST_RECV : ST_READ;
        end
      end
      default: state_d = ST_RECV;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_RECV: begin
        in_stall_o    = 1'b0;
        cmd_o.step_en = in_valid_i;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_SEND: begin
        out_valid_o   = 1'b1;
        cmd_o.cnt_inc = !out_stall_i;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/lppr_dpath.sv */
// Datapath for the packet receiver: header assembly, discard count,
// payload store and run counter. Depends on lppr_pkg and lppr_ram.
module lppr_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lppr_pkg::in_item_t   in_item_i,
  input  lppr_pkg::ctrl_cmd_t  cmd_i,
  output lppr_pkg::dp_status_t status_o,
  output lppr_pkg::out_item_t  out_item_o
);
  import lppr_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       hdr_lo_q, hdr_lo_d;
  logic [LenW-1:0]  acc_q, acc_d;
  logic [15:0]      discard_q, discard_d;
  logic             done_q, done_d;
  logic [AddrW-1:0] cnt_q;

  logic [15:0]      hdr_len;
  logic [PosW-1:0]  data_idx;
  logic             store_we;
  logic             run_start;
  logic [7:0]       rd_data;

  assign hdr_len  = {in_item_i.rx_byte, hdr_lo_q};
  assign data_idx = pos_q - PosW'(2);

  always_comb begin
    pos_d     = pos_q;
    hdr_lo_d  = hdr_lo_q;
    acc_d     = acc_q;
    discard_d = discard_q;
    done_d    = done_q;
    store_we  = 1'b0;
    run_start = 1'b0;
    if (cmd_i.step_en) begin
      priority if (in_item_i.operation == OpAck) begin
        // ack only frees a finished packet
        if (!done_q && pos_q == '0) begin
          done_d = 1'b1;
        end
      end else if (discard_q != '0) begin
        discard_d = discard_q - 16'd1;
        pos_d     = '0;
      end else if (pos_q == '0) begin
        hdr_lo_d = in_item_i.rx_byte;
        pos_d    = PosW'(1);
      end else if (pos_q == PosW'(1)) begin
        if (hdr_len > 16'(MaxPacket) || !done_q) begin
          discard_d = hdr_len;
          pos_d     = '0;
        end else begin
          done_d = 1'b0;
          acc_d  = LenW'(hdr_len);
          pos_d  = (hdr_len == '0) ? '0 : PosW'(2);
        end
      end else begin
        store_we = 1'b1;
        if ((pos_q - PosW'(1)) >= PosW'(acc_q)) begin
          pos_d     = '0;
          run_start = 1'b1;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      hdr_lo_q  <= '0;
      acc_q     <= '0;
      discard_q <= '0;
      done_q    <= 1'b1;
      cnt_q     <= '0;
    end else begin
      pos_q     <= pos_d;
      hdr_lo_q  <= hdr_lo_d;
      acc_q     <= acc_d;
      discard_q <= discard_d;
      done_q    <= done_d;
      if (run_start) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + AddrW'(1);
      end
    end
  end

  lppr_ram #(
    .Width (8),
    .Depth (MaxPacket)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (data_idx[AddrW-1:0]),
    .wdata_i (in_item_i.rx_byte),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cnt_q),
    .rdata_o (rd_data)
  );

  assign status_o.run_start = run_start;
  assign status_o.run_last  = ((LenW'(cnt_q) + LenW'(1)) == acc_q);

  assign out_item_o.packet_byte    = rd_data;
  assign out_item_o.byte_index     = 4'(cnt_q);
  assign out_item_o.packet_length  = 5'(acc_q);
  assign out_item_o.last_of_packet = status_o.run_last;

endmodule

/* rtl/length_prefixed_packet_receiver_top.sv */
// Top level of the length-prefixed packet receiver.
// Depends on lppr_pkg, lppr_ctrl, lppr_dpath (and lppr_ram below it).
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------
//   in      | in_valid_i / in_stall_o   | in_item_i  (lppr_pkg::in_item_t)
//   out     | out_valid_o / out_stall_i | out_item_o (lppr_pkg::out_item_t)
//
// An input item is taken whenever it is valid while a packet is being received.
// The data byte that completes a packet starts a run of n results; each one
// passes through a store read state and then a send state, which holds while
// the output is stalled, and input stalls for the whole run. Reset leaves the
// receiver free and waiting for a header; the payload store needs no clearing.
module length_prefixed_packet_receiver_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lppr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lppr_pkg::out_item_t out_item_o
);
  import lppr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lppr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lppr_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule

/* rtl/lppr_checker.sv */
// Port-level checks for the packet receiver, bound to the top level.
// Depends on lppr_pkg.
module lppr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lppr_pkg::out_item_t out_item_o
);
  import lppr_pkg::*;

  // Input is held off for the whole run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during a run");

  // The last mark sits exactly on the final index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.last_of_packet ==
      (({1'b0, out_item_o.byte_index} + 5'd1) == out_item_o.packet_length)))
    else $error("last mark misplaced");

  // A run only covers lengths the store can hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.packet_length != 5'd0 &&
      out_item_o.packet_length <= 5'(MaxPacket)))
    else $error("bad run length");

  // A run continues until its last item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_item_o.last_of_packet) |=> in_stall_o)
    else $error("run ended early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled output item changed");

endmodule

bind length_prefixed_packet_receiver_top lppr_checker u_lppr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

/* bench/tb_length_prefixed_packet_receiver_top.sv */
// Testbench for length_prefixed_packet_receiver_top: directed rows, then random packet traffic.
// Each output item is checked against a local model of the receiver or against the value a directed row gives.
// Depends on lppr_pkg and the receiver RTL.
`timescale 1ns / 100ps

module tb_length_prefixed_packet_receiver_top;
  import lppr_pkg::*;

  localparam int unsigned ClkHalf       = 6;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TailCycles    = 40;
  localparam int unsigned RandomItems   = 190;
  localparam int unsigned MaxReports    = 10;

  localparam int unsigned SendIdlePct [4] = '{0, 78, 0, 12};
  localparam int unsigned RecvStallPct[4] = '{0, 0, 78, 12};

  // How the result of a stimulus row is known.
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_ONE
  } row_check_e;

  typedef struct packed {
    row_check_e check;
    in_item_t   item;
    out_item_t  want;
  } stim_row_t;

  localparam out_item_t NoResult = '0;

  localparam stim_row_t DirectedRows [23] = '{
    '{CHK_NONE,    '{OpAck,  8'hFF}, NoResult},  // ack while already free
    '{CHK_NONE,    '{OpByte, 8'h01}, NoResult},
    '{CHK_NONE,    '{OpByte, 8'h00}, NoResult},
    '{CHK_ONE,     '{OpByte, 8'hA5}, '{8'hA5, 4'd0, 5'd1, 1'b1}},
    '{CHK_NONE,    '{OpByte, 8'h02}, NoResult},  // header while unacknowledged
    '{CHK_NONE,    '{OpByte, 8'h00}, NoResult},
    '{CHK_NONE,    '{OpByte, 8'hFF}, NoResult},  // discarded
    '{CHK_NONE,    '{OpByte, 8'h00}, NoResult},  // discarded
    '{CHK_NONE,    '{OpAck,  8'h00}, NoResult},
    '{CHK_NONE,    '{OpByte, 8'h00}, NoResult},  // zero-length packet
    '{CHK_NONE,    '{OpByte, 8'h00}, NoResult},
    '{CHK_NONE,    '{OpByte, 8'h01}, NoResult},  // busy again after empty packet
    '{CHK_NONE,    '{OpByte, 8'h00}, NoResult},
    '{CHK_NONE,    '{OpByte, 8'h7E}, NoResult},  // discarded
    '{CHK_NONE,    '{OpAck,  8'h00}, NoResult},
    '{CHK_NONE,    '{OpByte, 8'h02}, NoResult},
    '{CHK_NONE,    '{OpByte, 8'h00}, NoResult},
    '{CHK_NONE,    '{OpAck,  8'h5A}, NoResult},  // ack mid-packet, ignored
    '{CHK_NONE,    '{OpByte, 8'h00}, NoResult},
    '{CHK_PREDICT, '{OpByte, 8'hFF}, NoResult},
    '{CHK_NONE,    '{OpAck,  8'h00}, NoResult},
    '{CHK_NONE,    '{OpByte, 8'h11}, NoResult},  // oversize header, 17 bytes
    '{CHK_NONE,    '{OpByte, 8'h00}, NoResult}
  };

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  row_check_e  row_check;
  out_item_t   row_want;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;
  int unsigned stream_count;

  // Receiver model state.
  logic [PosW-1:0] rx_pos;
  logic [15:0]     hdr_len;
  logic [LenW-1:0] acc_len;
  logic [15:0]     discard_left;
  logic            rx_free;
  logic [7:0]      payload_mem [MaxPacket];

  out_item_t run_bytes_q[$];
  out_item_t packet_bytes_due[$];
  out_item_t oldest_due;
  in_item_t  rx_stream[$];

  length_prefixed_packet_receiver_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #(ClkHalf);
    clk_i = 1'b1;
    #(ClkHalf);
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Apply one item to the model; the packet run it completes lands in run_bytes_q.
  function automatic void advance_receiver(input in_item_t it);
    int unsigned slot;
    out_item_t   res;
    run_bytes_q.delete();
    if (it.operation == OpAck) begin
      if (!rx_free && rx_pos == PosW'(0)) rx_free = 1'b1;
    end else if (discard_left != 16'd0) begin
      discard_left = discard_left - 16'd1;
      rx_pos = PosW'(0);
    end else if (rx_pos == PosW'(0)) begin
      hdr_len = {8'h00, it.rx_byte};
      rx_pos = PosW'(1);
    end else if (rx_pos == PosW'(1)) begin
      hdr_len[15:8] = it.rx_byte;
      if (hdr_len > MaxPacket || !rx_free) begin
        discard_left = hdr_len;
        rx_pos = PosW'(0);
      end else begin
        rx_free = 1'b0;
        acc_len = LenW'(hdr_len);
        rx_pos = (acc_len == LenW'(0)) ? PosW'(0) : PosW'(2);
      end
    end else begin
      slot = rx_pos - 2;
      payload_mem[slot] = it.rx_byte;
      if (slot + 1 >= acc_len) begin
        rx_pos = PosW'(0);
        for (int unsigned k = 0; k < acc_len; k++) begin
          res.packet_byte    = payload_mem[k];
          res.byte_index     = 4'(k);
          res.packet_length  = acc_len;
          res.last_of_packet = (k + 1 == acc_len);
          run_bytes_q.push_back(res);
        end
      end else begin
        rx_pos = rx_pos + PosW'(1);
      end
    end
  endfunction

  task automatic note_mismatch(input bit have_want, input out_item_t want,
                               input out_item_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports) begin
      if (have_want)
        $display("%0t: mismatch: expected byte %02h index %0d length %0d last %0b,",
                 $time, want.packet_byte, want.byte_index, want.packet_length,
                 want.last_of_packet,
                 " got byte %02h index %0d length %0d last %0b",
                 got.packet_byte, got.byte_index, got.packet_length, got.last_of_packet);
      else
        $display("%0t: unexpected item: byte %02h index %0d length %0d last %0b",
                 $time, got.packet_byte, got.byte_index, got.packet_length,
                 got.last_of_packet);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (packet_bytes_due.size() == 0) begin
          note_mismatch(1'b0, NoResult, out_item_o);
        end else begin
          oldest_due = packet_bytes_due.pop_front();
          if (out_item_o.packet_byte !== oldest_due.packet_byte ||
              out_item_o.byte_index !== oldest_due.byte_index ||
              out_item_o.packet_length !== oldest_due.packet_length ||
              out_item_o.last_of_packet !== oldest_due.last_of_packet)
            note_mismatch(1'b1, oldest_due, out_item_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        advance_receiver(in_item_i);
        case (row_check)
          CHK_PREDICT: foreach (run_bytes_q[k]) packet_bytes_due.push_back(run_bytes_q[k]);
          CHK_ONE:     packet_bytes_due.push_back(row_want);
          default: ;
        endcase
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("tb_length_prefixed_packet_receiver_top failed");
          $finish;
        end
      end
    end
  end

  function automatic void push_rx(input logic op, input logic [7:0] b, input bit counted);
    in_item_t it;
    it.operation = op;
    it.rx_byte   = b;
    rx_stream.push_back(it);
    if (counted) stream_count++;
  endfunction

  // Mostly well-formed packets; skipped acks, mid-packet acks, oversize headers
  // with matching filler and stray acks keep the stream aligned to headers.
  task automatic build_rx_stream();
    int unsigned pick;
    int unsigned len;
    int unsigned mid_ack;
    bit          first;
    first = 1'b1;
    // finish the discard left by the oversize directed header
    repeat (17) push_rx(OpByte, 8'($urandom_range(255)), 1'b0);
    while (stream_count < RandomItems) begin
      pick = $urandom_range(99);
      if (first || pick < 72) begin
        pick = $urandom_range(9);
        if (first) len = MaxPacket;
        else if (pick == 0) len = 0;
        else if (pick < 3) len = MaxPacket;
        else len = $urandom_range(MaxPacket - 1, 1);
        first   = 1'b0;
        mid_ack = ($urandom_range(9) == 0) ? len / 2 : MaxPacket + 1;
        push_rx(OpByte, 8'(len), 1'b1);
        push_rx(OpByte, 8'(len >> 8), 1'b1);
        for (int unsigned i = 0; i < len; i++) begin
          if (i == mid_ack) push_rx(OpAck, 8'($urandom_range(255)), 1'b1);
          push_rx(OpByte, 8'($urandom_range(255)), 1'b1);
        end
        if ($urandom_range(99) >= 15) push_rx(OpAck, 8'($urandom_range(255)), 1'b1);
      end else if (pick < 84) begin
        len = $urandom_range(40, MaxPacket + 1);
        push_rx(OpByte, 8'(len), 1'b1);
        push_rx(OpByte, 8'(len >> 8), 1'b1);
        for (int unsigned i = 0; i < len; i++)
          push_rx(OpByte, 8'($urandom_range(255)), 1'b1);
      end else begin
        repeat ($urandom_range(3, 1)) push_rx(OpAck, 8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  task automatic send_row(input stim_row_t row);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= row.item;
    row_check  <= row.check;
    row_want   <= row.want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    out_stall_i    = 1'b0;
    row_check      = CHK_PREDICT;
    row_want       = NoResult;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_cnt   = 0;
    quiet_cycles   = 0;
    stream_count   = 0;
    rx_pos         = PosW'(0);
    hdr_len        = 16'd0;
    acc_len        = LenW'(0);
    discard_left   = 16'd0;
    rx_free        = 1'b1;
    build_rx_stream();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i]) send_row(DirectedRows[i]);
    foreach (rx_stream[i]) begin
      send_idle_pct  = SendIdlePct[i * 4 / rx_stream.size()];
      recv_stall_pct = RecvStallPct[i * 4 / rx_stream.size()];
      send_row('{CHK_PREDICT, rx_stream[i], NoResult});
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain; the watchdog bounds this wait
    while (packet_bytes_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_cnt == 0 && packet_bytes_due.size() == 0)
      $display("tb_length_prefixed_packet_receiver_top passed");
    else
      $display("tb_length_prefixed_packet_receiver_top failed");
    $finish;
  end

endmodule
